@@ hdl/lexicographic_next_permutation_core_defines.svh @@
// Assertion macros for the next-permutation core.
// Included by the top level; no other dependencies.
`ifndef LEXICOGRAPHIC_NEXT_PERMUTATION_CORE_DEFINES_SVH
`define LEXICOGRAPHIC_NEXT_PERMUTATION_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define LNP_ASSERT_HOLDS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define LNP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define LNP_ASSERT_HOLDS(label, clk, rst_n, cond, msg)
`define LNP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ hdl/lnp_pkg.sv @@
// Shared widths, defaults and opcodes of the next-permutation core.
// No dependencies.
package lnp_pkg;
  localparam int OPCODE_W = 2;
  localparam int POSITION_W = 3;
  localparam int SYMBOL_W = 8;
  localparam int LENGTH_W = 4;
  localparam int MAX_LENGTH_DEFAULT = 8;
  localparam logic [LENGTH_W-1:0] LENGTH_RESET = 4'd8;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_FIRST = 2'd1,
    OP_NEXT  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;
endpackage

@@ hdl/lnp_stream_if.sv @@
// Valid/ready channel interfaces for the command and result streams.
// Depends on lnp_pkg for field widths.
interface lnp_in_if;
  import lnp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [OPCODE_W-1:0]   opcode;
  logic [POSITION_W-1:0] position;
  logic [SYMBOL_W-1:0]   symbol;
  modport source (output valid, opcode, position, symbol, input ready);
  modport sink (input valid, opcode, position, symbol, output ready);
endinterface

interface lnp_out_if;
  import lnp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [SYMBOL_W-1:0]   out_symbol;
  logic [POSITION_W-1:0] out_position;
  logic                  last;
  logic                  finished;
  modport source (output valid, out_symbol, out_position, last, finished, input ready);
  modport sink (input valid, out_symbol, out_position, last, finished, output ready);
endinterface

@@ hdl/lnp_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module lnp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ hdl/lexicographic_next_permutation_core.sv @@
// Next-permutation core: the row lives in a RAM with one read and one write port.
// Load writes one symbol; First bubble-sorts the row, then emits it.
// Next scans down for the pivot, searches down for its successor, does two swap writes,
// reverses the tail pair by pair through the one read port, then emits the row (one finished beat if no pivot).
// Items are taken one at a time in idle; output stalls stretch emission.
// Synchronous active-low reset clears control and sets the length to 8; row not cleared.
`include "lexicographic_next_permutation_core_defines.svh"
module lexicographic_next_permutation_core #(
  parameter int MAX_LENGTH = lnp_pkg::MAX_LENGTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  lnp_in_if.sink                       in_ch,
  lnp_out_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic [lnp_pkg::LENGTH_W-1:0] cfg_wdata
);
  import lnp_pkg::*;

  localparam int IW = $clog2(MAX_LENGTH);
  localparam int CW = $clog2(MAX_LENGTH + 2);
  localparam int EW = (CW > LENGTH_W) ? CW : LENGTH_W;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_SORT = 8'b0000_0010,
    S_SCAN = 8'b0000_0100,
    S_FIND = 8'b0000_1000,
    S_SWAP = 8'b0001_0000,
    S_REV  = 8'b0010_0000,
    S_EMIT = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_t;

  typedef enum logic [3:0] {
    RP_RDLO = 4'b0001,
    RP_RDHI = 4'b0010,
    RP_WRLO = 4'b0100,
    RP_WRHI = 4'b1000
  } rev_phase_t;

  state_t              state_r, state_nxt;
  rev_phase_t          rp_r, rp_nxt;
  logic [LENGTH_W-1:0] cfg_r;
  logic                ov_r, ov_nxt;
  logic [SYMBOL_W-1:0] osym_r, osym_nxt;
  logic [POSITION_W-1:0] opos_r, opos_nxt;
  logic                olast_r, olast_nxt;
  logic                ofin_r, ofin_nxt;
  logic [CW-1:0]       s_r, s_nxt;
  logic [CW-1:0]       pass_r, pass_nxt;
  logic [SYMBOL_W-1:0] hold_r, hold_nxt;
  logic [SYMBOL_W-1:0] prev_r, prev_nxt;
  logic [SYMBOL_W-1:0] iv_r, iv_nxt;
  logic [SYMBOL_W-1:0] jv_r, jv_nxt;
  logic [IW-1:0]       da_r, da_nxt;
  logic [IW-1:0]       i_r, i_nxt;
  logic [IW-1:0]       j_r, j_nxt;
  logic [IW-1:0]       lo_r, lo_nxt;
  logic [IW-1:0]       hi_r, hi_nxt;
  logic [IW-1:0]       ek_r, ek_nxt;
  logic                first_r, first_nxt;
  logic                dv_r, dv_nxt;

  logic                ram_we;
  logic [IW-1:0]       ram_waddr;
  logic [SYMBOL_W-1:0] ram_wdata;
  logic [IW-1:0]       ram_raddr;
  logic [SYMBOL_W-1:0] ram_rdata;

  logic [EW-1:0]       rl_ext;
  logic [EW-1:0]       pos_ext;
  logic [EW-1:0]       ek_ext;
  logic [CW-1:0]       n_len;
  logic [CW-1:0]       n_m1;
  logic [CW-1:0]       n_m2;
  logic [CW-1:0]       s_m2;
  logic [IW-1:0]       last_idx;
  logic [IW-1:0]       da_dec;
  logic [IW-1:0]       i_p1;
  logic                load_ok;

  lnp_ram #(
    .WIDTH(SYMBOL_W),
    .DEPTH(MAX_LENGTH)
  ) u_row_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    rl_ext = EW'(cfg_r);
    priority if (rl_ext == '0) begin
      n_len = CW'(1);
    end else if (rl_ext > EW'(MAX_LENGTH)) begin
      n_len = CW'(MAX_LENGTH);
    end else begin
      n_len = rl_ext[CW-1:0];
    end
  end

  assign n_m1     = n_len - CW'(1);
  assign n_m2     = n_len - CW'(2);
  assign s_m2     = s_r - CW'(2);
  assign last_idx = n_m1[IW-1:0];
  assign pos_ext  = EW'(in_ch.position);
  assign ek_ext   = EW'(ek_r);
  assign da_dec   = (da_r == '0) ? '0 : da_r - IW'(1);
  assign i_p1     = i_r + IW'(1);
  assign load_ok  = !ov_r || out_ch.ready;

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = ov_r;
  assign out_ch.out_symbol   = osym_r;
  assign out_ch.out_position = opos_r;
  assign out_ch.last         = olast_r;
  assign out_ch.finished     = ofin_r;

  always_comb begin
    state_nxt = state_r;
    rp_nxt    = rp_r;
    ov_nxt    = ov_r && !out_ch.ready;
    osym_nxt  = osym_r;
    opos_nxt  = opos_r;
    olast_nxt = olast_r;
    ofin_nxt  = ofin_r;
    s_nxt     = s_r;
    pass_nxt  = pass_r;
    hold_nxt  = hold_r;
    prev_nxt  = prev_r;
    iv_nxt    = iv_r;
    jv_nxt    = jv_r;
    da_nxt    = da_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    ek_nxt    = ek_r;
    first_nxt = first_r;
    dv_nxt    = dv_r;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          unique case (in_ch.opcode)
            OP_LOAD: begin
              if (pos_ext < EW'(MAX_LENGTH)) begin
                ram_we    = 1'b1;
                ram_waddr = pos_ext[IW-1:0];
                ram_wdata = in_ch.symbol;
              end
            end
            OP_FIRST: begin
              if (n_len == CW'(1)) begin
                state_nxt = S_EMIT;
                ek_nxt    = '0;
                dv_nxt    = 1'b0;
              end else begin
                state_nxt = S_SORT;
                s_nxt     = '0;
                pass_nxt  = '0;
              end
            end
            OP_NEXT: begin
              if (n_len == CW'(1)) begin
                state_nxt = S_FIN;
              end else begin
                ram_raddr = last_idx;
                da_nxt    = last_idx;
                first_nxt = 1'b1;
                state_nxt = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SORT: begin
        if (s_r < n_len) begin
          ram_raddr = s_r[IW-1:0];
        end
        s_nxt = s_r + CW'(1);
        priority if (s_r == CW'(1)) begin
          hold_nxt = ram_rdata;
        end else if (s_r >= CW'(2) && s_r <= n_len) begin
          ram_we    = 1'b1;
          ram_waddr = s_m2[IW-1:0];
          if (hold_r > ram_rdata) begin
            ram_wdata = ram_rdata;
          end else begin
            ram_wdata = hold_r;
            hold_nxt  = ram_rdata;
          end
        end else if (s_r > n_len) begin
          ram_we    = 1'b1;
          ram_waddr = last_idx;
          ram_wdata = hold_r;
          s_nxt     = '0;
          if (pass_r == n_m2) begin
            state_nxt = S_EMIT;
            ek_nxt    = '0;
            dv_nxt    = 1'b0;
          end else begin
            pass_nxt = pass_r + CW'(1);
          end
        end else begin
        end
      end

      S_SCAN: begin
        ram_raddr = da_dec;
        priority if (first_r) begin
          prev_nxt  = ram_rdata;
          da_nxt    = da_dec;
          first_nxt = 1'b0;
        end else if (ram_rdata < prev_r) begin
          i_nxt     = da_r;
          iv_nxt    = ram_rdata;
          ram_raddr = last_idx;
          da_nxt    = last_idx;
          state_nxt = S_FIND;
        end else if (da_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          prev_nxt = ram_rdata;
          da_nxt   = da_dec;
        end
      end

      S_FIND: begin
        ram_raddr = da_dec;
        if (ram_rdata > iv_r) begin
          j_nxt     = da_r;
          jv_nxt    = ram_rdata;
          first_nxt = 1'b1;
          state_nxt = S_SWAP;
        end else begin
          da_nxt = da_dec;
        end
      end

      S_SWAP: begin
        ram_we = 1'b1;
        if (first_r) begin
          ram_waddr = i_r;
          ram_wdata = jv_r;
          first_nxt = 1'b0;
        end else begin
          ram_waddr = j_r;
          ram_wdata = iv_r;
          lo_nxt    = i_p1;
          hi_nxt    = last_idx;
          if (i_p1 < last_idx) begin
            state_nxt = S_REV;
            rp_nxt    = RP_RDLO;
          end else begin
            state_nxt = S_EMIT;
            ek_nxt    = '0;
            dv_nxt    = 1'b0;
          end
        end
      end

      S_REV: begin
        unique case (rp_r)
          RP_RDLO: begin
            ram_raddr = lo_r;
            rp_nxt    = RP_RDHI;
          end
          RP_RDHI: begin
            ram_raddr = hi_r;
            prev_nxt  = ram_rdata;
            rp_nxt    = RP_WRLO;
          end
          RP_WRLO: begin
            ram_we    = 1'b1;
            ram_waddr = lo_r;
            ram_wdata = ram_rdata;
            rp_nxt    = RP_WRHI;
          end
          RP_WRHI: begin
            ram_we    = 1'b1;
            ram_waddr = hi_r;
            ram_wdata = prev_r;
            lo_nxt    = lo_r + IW'(1);
            hi_nxt    = hi_r - IW'(1);
            if ((lo_r + IW'(1)) < (hi_r - IW'(1))) begin
              ram_raddr = lo_r + IW'(1);
              rp_nxt    = RP_RDHI;
            end else begin
              state_nxt = S_EMIT;
              ek_nxt    = '0;
              dv_nxt    = 1'b0;
            end
          end
          default: begin
            rp_nxt = RP_RDLO;
          end
        endcase
      end

      S_EMIT: begin
        dv_nxt    = 1'b1;
        ram_raddr = ek_r;
        if (dv_r && load_ok) begin
          ov_nxt    = 1'b1;
          osym_nxt  = ram_rdata;
          opos_nxt  = ek_ext[POSITION_W-1:0];
          olast_nxt = (ek_r == last_idx);
          ofin_nxt  = 1'b0;
          if (ek_r == last_idx) begin
            ram_raddr = '0;
            state_nxt = S_IDLE;
          end else begin
            ram_raddr = ek_r + IW'(1);
            ek_nxt    = ek_r + IW'(1);
          end
        end
      end

      S_FIN: begin
        if (load_ok) begin
          ov_nxt    = 1'b1;
          osym_nxt  = '0;
          opos_nxt  = '0;
          olast_nxt = 1'b1;
          ofin_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rp_r    <= RP_RDLO;
      ov_r    <= 1'b0;
      cfg_r   <= LENGTH_RESET;
    end else begin
      state_r <= state_nxt;
      rp_r    <= rp_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    osym_r  <= osym_nxt;
    opos_r  <= opos_nxt;
    olast_r <= olast_nxt;
    ofin_r  <= ofin_nxt;
    s_r     <= s_nxt;
    pass_r  <= pass_nxt;
    hold_r  <= hold_nxt;
    prev_r  <= prev_nxt;
    iv_r    <= iv_nxt;
    jv_r    <= jv_nxt;
    da_r    <= da_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    ek_r    <= ek_nxt;
    first_r <= first_nxt;
    dv_r    <= dv_nxt;
  end

  `LNP_ASSERT_IMPL(a_emit_no_write, clk, rst_n, state_r == S_EMIT, !ram_we, "write in emit")
  `LNP_ASSERT_IMPL(a_rev_order, clk, rst_n, state_r == S_REV, lo_r < hi_r, "pointers crossed")
  `LNP_ASSERT_IMPL(a_swap_order, clk, rst_n, state_r == S_SWAP, j_r > i_r, "bad swap partner")
  `LNP_ASSERT_IMPL(a_fin_shape, clk, rst_n, ov_r && ofin_r, olast_r && opos_r == '0, "bad finish")
endmodule

@@ dv/lnp_permutation_checker.sv @@
// Checker for the next-permutation core: watches the command, result and length ports,
// predicts every emitted arrangement and compares it with the core's results.
// Depends on lnp_pkg and the stream interfaces lnp_in_if and lnp_out_if.
module lnp_permutation_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  lnp_in_if                            cmd_mon,
  lnp_out_if                           res_mon,
  input  logic                         cfg_we,
  input  logic [lnp_pkg::LENGTH_W-1:0] cfg_wdata,
  output int                           fail_count,
  output int                           pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import lnp_pkg::*;

  localparam int ROW_DEPTH = MAX_LENGTH_DEFAULT;

  typedef struct packed {
    logic [SYMBOL_W-1:0]   symbol;
    logic [POSITION_W-1:0] position;
    logic                  last;
    logic                  finished;
  } arrangement_beat_t;

  logic [SYMBOL_W-1:0] row_model [ROW_DEPTH];
  logic [LENGTH_W-1:0] length_reg;
  arrangement_beat_t   arrangement_q [$];

  task automatic queue_row(input int n);
    arrangement_beat_t beat;
    for (int k = 0; k < n; k++) begin
      beat.symbol   = row_model[k];
      beat.position = POSITION_W'(k);
      beat.last     = (k == n - 1);
      beat.finished = 1'b0;
      arrangement_q = {arrangement_q, beat};
    end
  endtask

  task automatic predict_permutation(input opcode_t op, input logic [POSITION_W-1:0] pos,
                                     input logic [SYMBOL_W-1:0] sym);
    int n;
    int i;
    int j;
    int lo;
    int hi;
    bit found;
    logic [SYMBOL_W-1:0] tmp;
    arrangement_beat_t beat;
    if (length_reg == '0) begin
      n = 1;
    end else if (int'(length_reg) > ROW_DEPTH) begin
      n = ROW_DEPTH;
    end else begin
      n = int'(length_reg);
    end
    case (op)
      OP_LOAD: begin
        row_model[pos] = sym;
      end
      OP_FIRST: begin
        for (int a = 0; a < n - 1; a++) begin
          for (int c = 0; c < n - 1 - a; c++) begin
            if (row_model[c] > row_model[c + 1]) begin
              tmp              = row_model[c];
              row_model[c]     = row_model[c + 1];
              row_model[c + 1] = tmp;
            end
          end
        end
        queue_row(n);
      end
      OP_NEXT: begin
        found = 1'b0;
        i = 0;
        for (int t = n - 1; t > 0 && !found; t--) begin
          if (row_model[t - 1] < row_model[t]) begin
            i = t - 1;
            found = 1'b1;
          end
        end
        if (!found) begin
          beat.symbol   = '0;
          beat.position = '0;
          beat.last     = 1'b1;
          beat.finished = 1'b1;
          arrangement_q = {arrangement_q, beat};
        end else begin
          j = n - 1;
          while (j > i && row_model[j] <= row_model[i]) j--;
          tmp          = row_model[i];
          row_model[i] = row_model[j];
          row_model[j] = tmp;
          lo = i + 1;
          hi = n - 1;
          while (lo < hi) begin
            tmp           = row_model[lo];
            row_model[lo] = row_model[hi];
            row_model[hi] = tmp;
            lo++;
            hi--;
          end
          queue_row(n);
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    arrangement_beat_t got;
    arrangement_beat_t want;
    if (!rst_n) begin
      length_reg = LENGTH_RESET;
      arrangement_q.delete();
      fail_count = 0;
      for (int k = 0; k < ROW_DEPTH; k++) row_model[k] = '0;
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        got.symbol   = res_mon.out_symbol;
        got.position = res_mon.out_position;
        got.last     = res_mon.last;
        got.finished = res_mon.finished;
        if (arrangement_q.size() == 0) begin
          fail_count++;
          $display("%0t: extra result, expected none, actual %0d/%0d/%0b/%0b",
                   $time, got.symbol, got.position, got.last, got.finished);
        end else begin
          want = arrangement_q.pop_front();
          if (got.symbol !== want.symbol || got.position !== want.position ||
              got.last !== want.last || got.finished !== want.finished) begin
            fail_count++;
            $display("%0t: mismatch, expected %0d/%0d/%0b/%0b, actual %0d/%0d/%0b/%0b",
                     $time, want.symbol, want.position, want.last, want.finished,
                     got.symbol, got.position, got.last, got.finished);
          end
        end
      end
      if (cfg_we) length_reg = cfg_wdata;
      if (cmd_mon.valid && cmd_mon.ready) begin
        predict_permutation(opcode_t'(cmd_mon.opcode), cmd_mon.position, cmd_mon.symbol);
      end
    end
    pending_count = arrangement_q.size();
  end
endmodule

@@ dv/tb_lexicographic_next_permutation_core.sv @@
// Top of the next-permutation core testbench: clock, reset, command stimulus, result
// back-pressure and the verdict. Depends on lnp_pkg, the stream interfaces, the core
// and lnp_permutation_checker.
module tb_lexicographic_next_permutation_core;
  timeunit 1ns;
  timeprecision 1ps;
  import lnp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 200;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_PER_PHASE = 6;
  localparam int PHASES = 12;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [LENGTH_W-1:0] cfg_wdata;
  int                  sender_idle_pct = 0;
  int                  receiver_stall_pct = 0;
  int                  hold_requests = 0;
  int                  holds_served = 0;
  int                  cycle_count = 0;
  int                  fail_count;
  int                  pending_count;

  lnp_in_if  cmd_if ();
  lnp_out_if res_if ();

  lexicographic_next_permutation_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (cmd_if),
    .out_ch    (res_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  lnp_permutation_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_mon       (cmd_if),
    .res_mon       (res_if),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_served) begin
        holds_served = holds_served + 1;
        res_if.ready <= 1'b0;
        for (int k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
      end else begin
        res_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  task automatic send_command(input logic [OPCODE_W-1:0] op, input logic [POSITION_W-1:0] pos,
                              input logic [SYMBOL_W-1:0] sym);
    while ($urandom_range(99) < sender_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid    <= 1'b1;
    cmd_if.opcode   <= op;
    cmd_if.position <= pos;
    cmd_if.symbol   <= sym;
    do @(posedge clk); while (!cmd_if.ready);
  endtask

  task automatic settle();
    cmd_if.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(input logic [LENGTH_W-1:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [SYMBOL_W-1:0] pick_symbol();
    return ($urandom_range(1) == 0) ? SYMBOL_W'($urandom_range(3)) :
                                      SYMBOL_W'($urandom_range(255));
  endfunction

  initial begin
    logic [LENGTH_W-1:0] phase_lengths [PHASES];
    int r;
    int n;
    cmd_if.valid    <= 1'b0;
    cmd_if.opcode   <= OP_LOAD;
    cmd_if.position <= '0;
    cmd_if.symbol   <= '0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    rst_n           <= 1'b0;
    phase_lengths = '{4'd8, 4'd3, 4'd9, 4'd1, 4'd5, 4'd2, 4'd4, 4'd12, 4'd6, 4'd7, 4'd0, 4'd15};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_command(OP_LOAD, 3'd0, 8'd255);
    send_command(OP_LOAD, 3'd1, 8'd0);
    send_command(OP_LOAD, 3'd2, 8'd128);
    send_command(OP_LOAD, 3'd3, 8'd127);
    send_command(OP_LOAD, 3'd4, 8'd1);
    send_command(OP_LOAD, 3'd5, 8'd254);
    send_command(OP_LOAD, 3'd6, 8'h55);
    send_command(OP_LOAD, 3'd7, 8'h55);
    send_command(OP_NOP, 3'd7, 8'd255);
    send_command(OP_FIRST, 3'd0, 8'd0);
    send_command(OP_NEXT, 3'd0, 8'd0);
    send_command(OP_NEXT, 3'd0, 8'd0);

    write_length(4'd2);
    send_command(OP_LOAD, 3'd0, 8'd200);
    send_command(OP_LOAD, 3'd1, 8'd100);
    send_command(OP_NEXT, 3'd0, 8'd0);
    send_command(OP_FIRST, 3'd0, 8'd0);
    send_command(OP_NEXT, 3'd0, 8'd0);
    send_command(OP_NEXT, 3'd0, 8'd0);
    write_length(4'd1);
    send_command(OP_NEXT, 3'd0, 8'd0);
    write_length(4'd0);
    send_command(OP_FIRST, 3'd0, 8'd0);
    write_length(4'd15);
    send_command(OP_FIRST, 3'd0, 8'd0);

    for (int phase = 0; phase < PHASES; phase++) begin
      write_length(phase_lengths[phase]);
      case (phase % 4)
        0: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 75;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 75;
        end
        default: begin
          sender_idle_pct = 29;
          receiver_stall_pct = 29;
        end
      endcase
      if (phase == 4) hold_requests <= hold_requests + 1;
      n = (phase_lengths[phase] == 0) ? 1 :
          (int'(phase_lengths[phase]) > MAX_LENGTH_DEFAULT) ? MAX_LENGTH_DEFAULT :
          int'(phase_lengths[phase]);
      for (int k = 0; k < n; k++) begin
        send_command(OP_LOAD, POSITION_W'(k), pick_symbol());
      end
      send_command(OP_FIRST, POSITION_W'($urandom_range(7)), SYMBOL_W'($urandom_range(255)));
      for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
        r = $urandom_range(99);
        if (r < 12) begin
          send_command(OP_LOAD, POSITION_W'($urandom_range(7)), pick_symbol());
        end else if (r < 20) begin
          send_command(OP_FIRST, POSITION_W'($urandom_range(7)), SYMBOL_W'($urandom_range(255)));
        end else if (r < 25) begin
          send_command(OP_NOP, POSITION_W'($urandom_range(7)), SYMBOL_W'($urandom_range(255)));
        end else begin
          send_command(OP_NEXT, POSITION_W'($urandom_range(7)), SYMBOL_W'($urandom_range(255)));
        end
      end
    end

    settle();
    if (fail_count == 0 && pending_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+hdl
hdl/lnp_pkg.sv
hdl/lnp_stream_if.sv
hdl/lnp_ram.sv
hdl/lexicographic_next_permutation_core.sv
dv/lnp_permutation_checker.sv
dv/tb_lexicographic_next_permutation_core.sv
